// ----- rtl/rrm_pkg.sv -----
// shared constants, types and helpers of the residency manager
package rrm_pkg;

   localparam int NUM_ENTRIES = 1024;
   localparam int RING_MARGIN = 16;
   localparam int COUNT_WIDTH = 16;

   localparam int RING_SLOTS  = NUM_ENTRIES + RING_MARGIN;
   localparam int TBL_AW      = $clog2(NUM_ENTRIES);
   localparam int RING_AW     = $clog2(RING_SLOTS);

   localparam int OP_W        = 2;
   localparam int ID_W        = 10;
   localparam int ACTION_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int RSP_COUNT_W = 16;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [OP_W-1:0] OP_REFERENCE = OP_W'(0);
   localparam logic [OP_W-1:0] OP_RELEASE   = OP_W'(1);
   localparam logic [OP_W-1:0] OP_UPDATE    = OP_W'(2);

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE     = 3'd0,
      ACT_LOAD     = 3'd1,
      ACT_RESIDENT = 3'd2,
      ACT_FREE     = 3'd3,
      ACT_DROPPED  = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_UNREF     = 2'd1,
      STS_QUEUED    = 2'd2,
      STS_SATURATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SRC_NONE    = 2'd0,
      SRC_RELEASE = 2'd1,
      SRC_LOAD    = 2'd2
   } ring_src_type;

   // one word of the entry table
   typedef struct packed {
      logic                   resident;
      logic                   rel_mark;
      logic                   ordered;
      logic [COUNT_WIDTH-1:0] count;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic fetch;
      logic exec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic to_ring;
      logic out_free;
   } sts_type;

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] ptr);
      return (ptr == RING_AW'(RING_SLOTS - 1)) ? '0 : ptr + 1'b1;
   endfunction

endpackage

// ----- rtl/rrm_if.sv -----
// request and response channel interfaces
interface rrm_req_if import rrm_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] operation;
   logic [ID_W-1:0] entry_id;

   modport source (output valid, operation, entry_id, input ready);
   modport sink   (input valid, operation, entry_id, output ready);
endinterface

interface rrm_rsp_if import rrm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [ID_W-1:0]        action_id;
   logic [STATUS_W-1:0]    status;
   logic [RSP_COUNT_W-1:0] ref_count;
   logic                   work_pending;

   modport source (output valid, action, action_id, status, ref_count, work_pending,
                   input ready);
   modport sink   (input valid, action, action_id, status, ref_count, work_pending,
                   output ready);
endinterface

// ----- rtl/rrm_ctrl.sv -----
// sequencing state machine of the residency manager
module rrm_ctrl import rrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_FETCH = 4'b0100,
      S_EXEC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.to_ring ? S_FETCH : S_EXEC;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rrm_datapath.sv -----
// entry table, load and release rings, and response register
module rrm_datapath import rrm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [ID_W-1:0]        req_entry_id,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ACTION_W-1:0]    rsp_action,
   output logic [ID_W-1:0]        rsp_action_id,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [RSP_COUNT_W-1:0] rsp_ref_count,
   output logic                   rsp_work_pending
);

   entry_type       tbl_mem [NUM_ENTRIES];
   logic [ID_W-1:0] load_ring [RING_SLOTS];
   logic [ID_W-1:0] rel_ring  [RING_SLOTS];

   entry_type       tbl_rd_ff;
   logic [ID_W-1:0] load_rd_ff, rel_rd_ff;

   logic [TBL_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [RING_AW-1:0] load_head_ff, load_head_in, load_tail_ff, load_tail_in;
   logic [RING_AW-1:0] rel_head_ff, rel_head_in, rel_tail_ff, rel_tail_in;

   logic [OP_W-1:0] op_ff;
   logic [ID_W-1:0] id_ff, id_in;
   logic            in_range_ff;
   ring_src_type    src_ff, src_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   action_type             action_ff;
   logic [ID_W-1:0]        action_id_ff;
   status_type             status_ff;
   logic [RSP_COUNT_W-1:0] count_ff;
   logic                   pending_ff;

   logic              req_in_range, load_empty, rel_empty;
   logic              tbl_rd_en;
   logic [TBL_AW-1:0] tbl_rd_addr;

   entry_type              entry_new;
   logic                   tbl_we, push_load, push_rel, pop_load, pop_rel;
   action_type             action_new;
   logic [ID_W-1:0]        action_id_new;
   status_type             status_new;
   logic [RSP_COUNT_W-1:0] count_new;
   logic                   pending_new;

   // request decode
   assign req_in_range = 32'(req_entry_id) < 32'(NUM_ENTRIES);
   assign load_empty   = load_head_ff == load_tail_ff;
   assign rel_empty    = rel_head_ff == rel_tail_ff;

   always_comb begin
      src_in = SRC_NONE;
      if (req_operation == OP_UPDATE) begin
         if (!rel_empty) begin
            src_in = SRC_RELEASE;
         end else if (!load_empty) begin
            src_in = SRC_LOAD;
         end
      end
   end

   assign sts.to_ring    = src_in != SRC_NONE;
   assign sts.clear_last = clr_cnt_ff == TBL_AW'(NUM_ENTRIES - 1);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // entry id: from the request, replaced by the ring head on an update that serves a ring
   assign id_in       = cmd.fetch ? ((src_ff == SRC_RELEASE) ? rel_rd_ff : load_rd_ff)
                                  : req_entry_id;
   assign tbl_rd_en   = cmd.accept || cmd.fetch;
   assign tbl_rd_addr = TBL_AW'(id_in);
   assign clr_cnt_in  = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_operation;
         in_range_ff <= req_in_range;
         src_ff      <= src_in;
      end
      if (tbl_rd_en) begin
         id_ff <= id_in;
      end
   end

   // read-modify-write of one entry
   always_comb begin
      entry_new     = tbl_rd_ff;
      tbl_we        = 1'b0;
      push_load     = 1'b0;
      push_rel      = 1'b0;
      pop_load      = 1'b0;
      pop_rel       = 1'b0;
      action_new    = ACT_NONE;
      action_id_new = '0;
      status_new    = STS_OK;
      count_new     = '0;
      case (op_ff)
         OP_REFERENCE: begin
            if (in_range_ff) begin
               tbl_we = 1'b1;
               if (tbl_rd_ff.count == COUNT_MAX) begin
                  status_new = STS_SATURATED;
               end else begin
                  entry_new.count = tbl_rd_ff.count + 1'b1;
                  if (tbl_rd_ff.count == '0 && !tbl_rd_ff.resident && !tbl_rd_ff.ordered) begin
                     entry_new.ordered = 1'b1;
                     push_load         = 1'b1;
                     status_new        = STS_QUEUED;
                  end
               end
               count_new = RSP_COUNT_W'(entry_new.count);
            end
         end
         OP_RELEASE: begin
            if (in_range_ff) begin
               tbl_we = 1'b1;
               if (tbl_rd_ff.count == '0) begin
                  status_new = STS_UNREF;
               end else begin
                  entry_new.count = tbl_rd_ff.count - 1'b1;
                  if (entry_new.count == '0 && !tbl_rd_ff.rel_mark) begin
                     entry_new.rel_mark = 1'b1;
                     push_rel           = 1'b1;
                     status_new         = STS_QUEUED;
                  end
               end
               count_new = RSP_COUNT_W'(entry_new.count);
            end
         end
         OP_UPDATE: begin
            case (src_ff)
               SRC_RELEASE: begin
                  tbl_we        = 1'b1;
                  pop_rel       = 1'b1;
                  action_id_new = id_ff;
                  if (!tbl_rd_ff.ordered && tbl_rd_ff.count == '0 && tbl_rd_ff.rel_mark) begin
                     entry_new.resident = 1'b0;
                     action_new         = ACT_FREE;
                  end else begin
                     action_new = ACT_DROPPED;
                  end
                  entry_new.rel_mark = 1'b0;
               end
               SRC_LOAD: begin
                  tbl_we        = 1'b1;
                  pop_load      = 1'b1;
                  action_id_new = id_ff;
                  if (!tbl_rd_ff.resident) begin
                     entry_new.resident = 1'b1;
                     action_new         = ACT_LOAD;
                  end else begin
                     action_new = ACT_RESIDENT;
                  end
                  entry_new.ordered = 1'b0;
               end
               default: begin
                  action_new = ACT_NONE;
               end
            endcase
         end
         default: begin
            status_new = STS_OK;
         end
      endcase
   end

   // ring pointers move only on commit
   assign load_tail_in = (cmd.exec && push_load) ? ring_next(load_tail_ff) : load_tail_ff;
   assign load_head_in = (cmd.exec && pop_load)  ? ring_next(load_head_ff) : load_head_ff;
   assign rel_tail_in  = (cmd.exec && push_rel)  ? ring_next(rel_tail_ff)  : rel_tail_ff;
   assign rel_head_in  = (cmd.exec && pop_rel)   ? ring_next(rel_head_ff)  : rel_head_ff;
   assign pending_new  = (load_head_in != load_tail_in) || (rel_head_in != rel_tail_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         load_head_ff <= '0;
         load_tail_ff <= '0;
         rel_head_ff  <= '0;
         rel_tail_ff  <= '0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         load_head_ff <= load_head_in;
         load_tail_ff <= load_tail_in;
         rel_head_ff  <= rel_head_in;
         rel_tail_ff  <= rel_tail_in;
      end
   end

   // entry table
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         tbl_mem[clr_cnt_ff] <= '0;
      end else if (cmd.exec && tbl_we) begin
         tbl_mem[TBL_AW'(id_ff)] <= entry_new;
      end
      if (tbl_rd_en) begin
         tbl_rd_ff <= tbl_mem[tbl_rd_addr];
      end
   end

   // rings
   always_ff @(posedge clock) begin
      if (cmd.exec && push_load) begin
         load_ring[load_tail_ff] <= id_ff;
      end
      if (cmd.exec && push_rel) begin
         rel_ring[rel_tail_ff] <= id_ff;
      end
      if (cmd.accept) begin
         load_rd_ff <= load_ring[load_head_ff];
         rel_rd_ff  <= rel_ring[rel_head_ff];
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.exec) begin
         action_ff    <= action_new;
         action_id_ff <= action_id_new;
         status_ff    <= status_new;
         count_ff     <= count_new;
         pending_ff   <= pending_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = action_ff;
   assign rsp_action_id    = action_id_ff;
   assign rsp_status       = status_ff;
   assign rsp_ref_count    = count_ff;
   assign rsp_work_pending = pending_ff;

endmodule

// ----- rtl/refcounted_residency_manager.sv -----
// sequence: reference, release and an update with both rings empty go from accept to commit;
//   an update that serves a ring first fetches the entry at the ring head, then commits
// flow: one request in flight; a new request is taken only after the last one commits, set by
//   the read-modify-write of the entry table in synchronous memory, and a response not yet
//   taken holds back the commit
// reset: synchronous; a clearing pass zeroes all 1024 entries of the entry table, ready stays
//   low until it ends; ring pointers and response valid clear at once
module refcounted_residency_manager import rrm_pkg::*; (
   input logic      clock,
   input logic      reset,
   rrm_req_if.sink  req_if,
   rrm_rsp_if.source rsp_if
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: clear pass, idle, ring fetch, commit
   rrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entry table, rings and the response register
   rrm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_if.operation),
      .req_entry_id     (req_if.entry_id),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_action       (rsp_if.action),
      .rsp_action_id    (rsp_if.action_id),
      .rsp_status       (rsp_if.status),
      .rsp_ref_count    (rsp_if.ref_count),
      .rsp_work_pending (rsp_if.work_pending)
   );

`ifndef SYNTHESIS
   // no request taken while the table is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !(req_if.valid && req_if.ready))
      else $error("request accepted during clearing pass");

   // a commit always leaves a response waiting
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_if.valid)
      else $error("commit without response");

   // a new response only appears after a commit
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(cmd.exec))
      else $error("response without commit");

   // commit never overwrites a response that was not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !cmd.exec)
      else $error("response overwritten");
`endif

endmodule
